FILE: rtl/core/cbc_pkg.sv
package cbc_pkg;

  // Fixed geometry
  localparam int unsigned ROM_BANK_BYTES = 16384;
  localparam int unsigned RAM_BANK_BYTES = 8192;
  localparam int unsigned MAX_ROM_BANKS  = 512;
  localparam int unsigned MAX_RAM_BANKS  = 16;

  localparam int unsigned ROM_OFS_W  = $clog2(ROM_BANK_BYTES);
  localparam int unsigned RAM_OFS_W  = $clog2(RAM_BANK_BYTES);
  localparam int unsigned ROM_BANK_W = $clog2(MAX_ROM_BANKS);
  localparam int unsigned RAM_BANK_W = $clog2(MAX_RAM_BANKS);

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Register byte addresses
  localparam logic [PADDR_W-1:0] ADDR_MAPPER_KIND    = 4'h0;
  localparam logic [PADDR_W-1:0] ADDR_ROM_BANK_COUNT = 4'h4;
  localparam logic [PADDR_W-1:0] ADDR_RAM_BANK_COUNT = 4'h8;

  // Mapper kinds
  localparam logic [1:0] MAP_PLAIN = 2'd0;
  localparam logic [1:0] MAP_MBC1  = 2'd1;
  localparam logic [1:0] MAP_MBC5  = 2'd2;
  localparam logic [1:0] MAP_NONE  = 2'd3;

  // Regions
  localparam logic [1:0] RGN_FIXED_ROM = 2'd0;
  localparam logic [1:0] RGN_BANK_ROM  = 2'd1;
  localparam logic [1:0] RGN_EXT_RAM   = 2'd2;

  // Memory operations
  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_ROM_RD = 2'd1;
  localparam logic [1:0] OP_RAM_RD = 2'd2;
  localparam logic [1:0] OP_RAM_WR = 2'd3;

  // Write decode constants
  localparam logic [13:0] OFS_BANK_SEL  = 14'h2000;
  localparam logic [13:0] OFS_BANK_HIGH = 14'h3000;
  localparam logic [7:0]  VAL_RAM_EN    = 8'h0A;
  localparam logic [3:0]  NIB_RAM_EN    = 4'hA;
  localparam logic [9:0]  MBC1_BIG_ROM  = 10'd32;

  typedef struct packed {
    logic [1:0] mapper_kind;
    logic [9:0] rom_bank_count;
    logic [4:0] ram_bank_count;
  } cbc_cfg_t;

  typedef struct packed {
    logic        action;
    logic [1:0]  region;
    logic [13:0] offset;
    logic [7:0]  write_value;
  } cbc_in_t;

  typedef struct packed {
    logic [1:0]  mem_op;
    logic [22:0] rom_address;
    logic [16:0] ram_address;
    logic [7:0]  ram_write_value;
    logic        open_bus;
  } cbc_out_t;

endpackage

FILE: rtl/core/cbc_cfg.sv
module cbc_cfg
  import cbc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cbc_cfg_t           cfg
);

  cbc_cfg_t cfg_r, cfg_nxt;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr)
        ADDR_MAPPER_KIND:    cfg_nxt.mapper_kind    = pwdata[1:0];
        ADDR_ROM_BANK_COUNT: cfg_nxt.rom_bank_count = pwdata[9:0];
        ADDR_RAM_BANK_COUNT: cfg_nxt.ram_bank_count = pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr)
      ADDR_MAPPER_KIND:    prdata = {{(PDATA_W-2){1'b0}}, cfg_r.mapper_kind};
      ADDR_ROM_BANK_COUNT: prdata = {{(PDATA_W-10){1'b0}}, cfg_r.rom_bank_count};
      ADDR_RAM_BANK_COUNT: prdata = {{(PDATA_W-5){1'b0}}, cfg_r.ram_bank_count};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mapper_kind    <= MAP_PLAIN;
      cfg_r.rom_bank_count <= 10'd2;
      cfg_r.ram_bank_count <= 5'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/core/cbc_mapper.sv
module cbc_mapper
  import cbc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cbc_cfg_t cfg,
  input  logic     item_en,   // item leaves the input register this cycle
  input  cbc_in_t  item,
  output cbc_out_t result
);

  // Mapper state
  logic       mbc1_ram_on_r,     mbc1_ram_on_nxt;
  logic [4:0] mbc1_low_bank_r,   mbc1_low_bank_nxt;
  logic [1:0] mbc1_upper_bits_r, mbc1_upper_bits_nxt;
  logic       mbc1_mode_r,       mbc1_mode_nxt;
  logic       mbc5_ram_on_r,     mbc5_ram_on_nxt;
  logic [8:0] mbc5_rom_bank_r,   mbc5_rom_bank_nxt;
  logic [7:0] mbc5_ram_bank_r,   mbc5_ram_bank_nxt;

  logic [ROM_BANK_W-1:0] rom_mask;
  logic [RAM_BANK_W-1:0] ram_mask;
  logic [9:0]            rbc_m1;
  logic [4:0]            ramc_m1;
  logic                  has_ram, big_rom, wr, lo_ofs;
  logic                  do_rom, do_ram, open;
  logic [ROM_BANK_W-1:0] rom_bank;
  logic [RAM_BANK_W-1:0] ram_blk;
  logic [4:0]            mbc1_low_eff;

  assign rbc_m1   = (cfg.rom_bank_count != '0) ? cfg.rom_bank_count - 10'd1 : '0;
  assign ramc_m1  = (cfg.ram_bank_count != '0) ? cfg.ram_bank_count - 5'd1 : '0;
  assign rom_mask = rbc_m1[ROM_BANK_W-1:0];
  assign ram_mask = ramc_m1[RAM_BANK_W-1:0];
  assign has_ram  = cfg.ram_bank_count != '0;
  assign big_rom  = cfg.rom_bank_count > MBC1_BIG_ROM;
  assign wr       = item.action;
  assign lo_ofs   = item.offset < OFS_BANK_SEL;
  assign mbc1_low_eff = (mbc1_low_bank_r != '0) ? mbc1_low_bank_r : 5'd1;

  always_comb begin
    do_rom   = 1'b0;
    do_ram   = 1'b0;
    open     = 1'b0;
    rom_bank = '0;
    ram_blk  = '0;

    mbc1_ram_on_nxt     = mbc1_ram_on_r;
    mbc1_low_bank_nxt   = mbc1_low_bank_r;
    mbc1_upper_bits_nxt = mbc1_upper_bits_r;
    mbc1_mode_nxt       = mbc1_mode_r;
    mbc5_ram_on_nxt     = mbc5_ram_on_r;
    mbc5_rom_bank_nxt   = mbc5_rom_bank_r;
    mbc5_ram_bank_nxt   = mbc5_ram_bank_r;

    case (cfg.mapper_kind)
      MAP_PLAIN: begin
        if (item.region == RGN_FIXED_ROM && !wr) begin
          do_rom = 1'b1;
        end else if (item.region == RGN_BANK_ROM && !wr) begin
          do_rom   = 1'b1;
          rom_bank = ROM_BANK_W'(1);
        end else if (item.region == RGN_EXT_RAM && has_ram) begin
          do_ram = 1'b1;
        end else if (!wr) begin
          open = 1'b1;
        end
      end
      MAP_MBC1: begin
        if (item.region == RGN_FIXED_ROM && !wr) begin
          do_rom = 1'b1;
          if (mbc1_mode_r && big_rom)
            rom_bank = ROM_BANK_W'({mbc1_upper_bits_r, 5'd0}) & rom_mask;
        end else if (item.region == RGN_BANK_ROM && !wr) begin
          do_rom = 1'b1;
          if (big_rom)
            rom_bank = ROM_BANK_W'({mbc1_upper_bits_r, mbc1_low_eff}) & rom_mask;
          else
            rom_bank = ROM_BANK_W'(mbc1_low_eff) & rom_mask;
        end else if (item.region == RGN_FIXED_ROM) begin
          if (lo_ofs) begin
            if (item.write_value == VAL_RAM_EN)      mbc1_ram_on_nxt = 1'b1;
            else if (item.write_value == 8'd0)       mbc1_ram_on_nxt = 1'b0;
          end else begin
            mbc1_low_bank_nxt = item.write_value[4:0];
          end
        end else if (item.region == RGN_BANK_ROM) begin
          if (lo_ofs)                       mbc1_upper_bits_nxt = item.write_value[1:0];
          else if (item.write_value <= 8'd1) mbc1_mode_nxt       = item.write_value[0];
        end else if (item.region == RGN_EXT_RAM && has_ram && mbc1_ram_on_r) begin
          do_ram = 1'b1;
          if (mbc1_mode_r && !big_rom)
            ram_blk = RAM_BANK_W'(mbc1_upper_bits_r) & ram_mask;
        end else if (!wr) begin
          open = 1'b1;
        end
      end
      MAP_MBC5: begin
        if (item.region == RGN_FIXED_ROM && !wr) begin
          do_rom = 1'b1;
        end else if (item.region == RGN_BANK_ROM && !wr) begin
          do_rom   = 1'b1;
          rom_bank = ROM_BANK_W'(mbc5_rom_bank_r) & rom_mask;
        end else if (item.region == RGN_FIXED_ROM) begin
          if (lo_ofs) begin
            if (item.write_value[3:0] == NIB_RAM_EN) mbc5_ram_on_nxt = 1'b1;
            else if (item.write_value == 8'd0)       mbc5_ram_on_nxt = 1'b0;
          end else if (item.offset < OFS_BANK_HIGH) begin
            mbc5_rom_bank_nxt = {mbc5_rom_bank_r[8], item.write_value};
          end else begin
            mbc5_rom_bank_nxt = {item.write_value[0], mbc5_rom_bank_r[7:0]};
          end
        end else if (item.region == RGN_BANK_ROM) begin
          if (lo_ofs) mbc5_ram_bank_nxt = item.write_value;
        end else if (item.region == RGN_EXT_RAM && has_ram && mbc5_ram_on_r) begin
          do_ram  = 1'b1;
          ram_blk = mbc5_ram_bank_r[RAM_BANK_W-1:0] & ram_mask;
        end else if (!wr) begin
          open = 1'b1;
        end
      end
      default: begin  // unsupported mapper
        open = !wr;
      end
    endcase
  end

  always_comb begin
    result = '0;
    if (do_rom) begin
      result.mem_op      = OP_ROM_RD;
      result.rom_address = {rom_bank, item.offset[ROM_OFS_W-1:0]};
    end else if (do_ram) begin
      result.mem_op          = wr ? OP_RAM_WR : OP_RAM_RD;
      result.ram_address     = {ram_blk, item.offset[RAM_OFS_W-1:0]};
      result.ram_write_value = wr ? item.write_value : 8'd0;
    end else begin
      result.mem_op   = OP_NONE;
      result.open_bus = open;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbc1_ram_on_r     <= 1'b0;
      mbc1_low_bank_r   <= '0;
      mbc1_upper_bits_r <= '0;
      mbc1_mode_r       <= 1'b0;
      mbc5_ram_on_r     <= 1'b0;
      mbc5_rom_bank_r   <= '0;
      mbc5_ram_bank_r   <= '0;
    end else if (item_en) begin
      mbc1_ram_on_r     <= mbc1_ram_on_nxt;
      mbc1_low_bank_r   <= mbc1_low_bank_nxt;
      mbc1_upper_bits_r <= mbc1_upper_bits_nxt;
      mbc1_mode_r       <= mbc1_mode_nxt;
      mbc5_ram_on_r     <= mbc5_ram_on_nxt;
      mbc5_rom_bank_r   <= mbc5_rom_bank_nxt;
      mbc5_ram_bank_r   <= mbc5_ram_bank_nxt;
    end
  end

endmodule

FILE: rtl/core/cartridge_bank_controller_top.sv
// Cartridge bank controller: takes one CPU cartridge access word per cycle
// (read/write, region, offset, data) and returns one result word telling the
// external memories what to do: a ROM read at a physical byte address, a RAM
// read or write at a physical byte address, nothing, or open bus (the CPU
// sees 0xFF). Writes into the ROM regions program the MBC1/MBC5 bank, enable
// and mode registers and give a result word with no memory operation.
// Throughput is one word per cycle with full back-to-back flow while
// out_stall is low; each word passes the input register, then the result
// register, and out_stall can hold it in between. The single decode and
// bank-select stage between those registers sets the rate. Mapper kind and
// bank counts sit in the APB registers (0x0 mapper_kind, 0x4 rom_bank_count,
// 0x8 ram_bank_count); change them only while no word is in flight.
module cartridge_bank_controller_top
  import cbc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  cbc_in_t            in_data,

  output logic               out_valid,
  input  logic               out_stall,
  output cbc_out_t           out_data,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cbc_cfg_t cfg;
  cbc_in_t  in_data_r;
  logic     in_valid_r, in_valid_nxt;
  cbc_out_t out_data_r;
  logic     out_valid_r, out_valid_nxt;
  cbc_out_t result;
  logic     advance;    // result register can take a new word
  logic     in_take;
  logic     item_en;

  cbc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Mapper state only moves when the word actually goes to the result
  // register, so results always see the state left by the previous word.
  cbc_mapper u_mapper (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item_en (item_en),
    .item    (in_data_r),
    .result  (result)
  );

  assign advance  = !out_valid_r || !out_stall;
  assign item_en  = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take)      in_valid_nxt = 1'b1;
    else if (advance) in_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) out_valid_nxt = in_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_data_r <= in_data;
    if (item_en) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
